// ===== rtl/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

	// Fixed field widths
	localparam int TRIG_LOW_W  = 8;
	localparam int TRIG_HIGH_W = 8;
	localparam int TIMEOUT_W   = 16;
	localparam int GAP_W       = 17;
	localparam int COUNT_W     = 17;
	localparam int DIST_W      = 18;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	// Register reset values
	localparam logic [TRIG_LOW_W-1:0]  TRIG_LOW_RST  = TRIG_LOW_W'(2);
	localparam logic [TRIG_HIGH_W-1:0] TRIG_HIGH_RST = TRIG_HIGH_W'(10);
	localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = TIMEOUT_W'(30000);
	localparam logic [GAP_W-1:0]       GAP_RST       = GAP_W'(50000);

	// Distance scaling: pulse * (10 << FRACTION_BITS) / 58, in 1/16 mm at 4 bits
	localparam int FRACTION_BITS = 4;
	localparam int DIST_SCALE    = 10 << FRACTION_BITS;
	localparam int DIST_DIVISOR  = 58;
	localparam int REM_W         = 6;
	localparam logic [DIST_W-1:0] DIST_STEP_Q = DIST_W'(DIST_SCALE / DIST_DIVISOR);
	localparam logic [REM_W-1:0]  DIST_STEP_R = REM_W'(DIST_SCALE % DIST_DIVISOR);
	localparam logic [REM_W:0]    DIST_DIV_C  = (REM_W + 1)'(DIST_DIVISOR);
	localparam logic [DIST_W-1:0] DIST_MAX    = '1;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIG_LOW  = 2'd0,
		REG_TRIG_HIGH = 2'd1,
		REG_TIMEOUT   = 2'd2,
		REG_IDLE_GAP  = 2'd3
	} cfg_idx_t;

	// Measurement phases
	typedef enum logic [2:0] {
		PH_TRIG_LOW  = 3'd0,
		PH_TRIG_HIGH = 3'd1,
		PH_WAIT_RISE = 3'd2,
		PH_MEASURE   = 3'd3,
		PH_IDLE      = 3'd4
	} phase_t;

	// Current configuration
	typedef struct packed {
		logic [TRIG_LOW_W-1:0]  trig_low;
		logic [TRIG_HIGH_W-1:0] trig_high;
		logic [TIMEOUT_W-1:0]   timeout;
		logic [GAP_W-1:0]       idle_gap;
	} cfg_t;

	// Sequencer commands to the distance unit
	typedef struct packed {
		logic start;
		logic step;
		logic capture;
		logic fail;
	} dist_ctrl_t;

endpackage

// ===== rtl/ultrasonic_echo_ranger_top.sv =====
// Top level of the ultrasonic echo ranger: stream stages, sequencer, distance unit.
//
//  channel  | direction | handshake            | payload
//  s_*      | in        | s_tvalid / s_tready  | s_tdata[0] echo_level
//  m_*      | out       | m_tvalid / m_tready  | trigger_level, distance, sample_done, timed_out
//  cfg_*    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per clock while the output is not stalled; an accepted item passes through
// the input register, then the result register, before it reaches m_tdata.
// The phase counter, the running distance accumulator and the result register
// all advance on the cycle the item leaves the input register.
// A stalled output holds the result; one more item waits in the input register.
// Reset clears the phase, counter, stored distance and valid flags; config takes defaults.
module ultrasonic_echo_ranger_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [uer_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] echo_level, [7:1] zero
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [uer_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [0] trigger_level,
	                                                       // [18:1] distance,
	                                                       // [19] sample_done,
	                                                       // [20] timed_out, [23:21] zero
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data
);

	uer_pkg::cfg_t               cfg;
	uer_pkg::dist_ctrl_t         ctrl;
	logic                        valid_s1;
	logic                        echo_s1;
	logic                        out_free;
	logic                        fire;
	logic                        trig_c;
	logic                        done_c;
	logic                        tmo_c;
	logic [uer_pkg::DIST_W-1:0]  dist_c;
	logic                        out_valid_q;
	logic [uer_pkg::OUT_TDATA_W-1:0] out_data_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign fire      = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			echo_s1 <= s_tdata[0];
		end
	end

	uer_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.echo_level    (echo_s1),
		.cfg           (cfg),
		.trigger_level (trig_c),
		.sample_done   (done_c),
		.timed_out     (tmo_c),
		.ctrl          (ctrl)
	);

	uer_dist u_dist (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.ctrl          (ctrl),
		.distance_next (dist_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= {3'b000, tmo_c, done_c, dist_c, trig_c};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/uer_cfg.sv =====
// Configuration register file for the echo ranger.
module uer_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data,
	output uer_pkg::cfg_t                    cfg
);

	uer_pkg::cfg_t cfg_q;

	// Write one register per accepted write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_low  <= uer_pkg::TRIG_LOW_RST;
			cfg_q.trig_high <= uer_pkg::TRIG_HIGH_RST;
			cfg_q.timeout   <= uer_pkg::TIMEOUT_RST;
			cfg_q.idle_gap  <= uer_pkg::GAP_RST;
		end else if (cfg_valid) begin
			unique case (uer_pkg::cfg_idx_t'(cfg_index))
				uer_pkg::REG_TRIG_LOW: begin
					cfg_q.trig_low <= cfg_data[uer_pkg::TRIG_LOW_W-1:0];
				end
				uer_pkg::REG_TRIG_HIGH: begin
					cfg_q.trig_high <= cfg_data[uer_pkg::TRIG_HIGH_W-1:0];
				end
				uer_pkg::REG_TIMEOUT: begin
					cfg_q.timeout <= cfg_data[uer_pkg::TIMEOUT_W-1:0];
				end
				uer_pkg::REG_IDLE_GAP: begin
					cfg_q.idle_gap <= cfg_data[uer_pkg::GAP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/uer_dist.sv =====
// Running distance accumulator: tracks pulse * scale / 58 as the pulse grows.
module uer_dist (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  uer_pkg::dist_ctrl_t           ctrl,
	output logic [uer_pkg::DIST_W-1:0]    distance_next
);

	logic [uer_pkg::DIST_W-1:0]  acc_q_q;
	logic [uer_pkg::REM_W-1:0]   acc_r_q;
	logic                        acc_sat_q;
	logic [uer_pkg::DIST_W-1:0]  dist_q;

	logic [uer_pkg::REM_W:0]     r_sum;
	logic                        carry;
	logic [uer_pkg::REM_W:0]     r_fix;
	logic [uer_pkg::DIST_W:0]    q_sum;
	logic [uer_pkg::DIST_W-1:0]  acc_val;

	// Add one microsecond worth of distance, carrying the remainder
	always_comb begin
		r_sum = {1'b0, acc_r_q} + {1'b0, uer_pkg::DIST_STEP_R};
		carry = (r_sum >= uer_pkg::DIST_DIV_C);
		r_fix = carry ? (r_sum - uer_pkg::DIST_DIV_C) : r_sum;
		q_sum = {1'b0, acc_q_q} + {1'b0, uer_pkg::DIST_STEP_Q}
			+ {{uer_pkg::DIST_W{1'b0}}, carry};
		acc_val = acc_sat_q ? uer_pkg::DIST_MAX : acc_q_q;
	end

	// Stored distance after this item
	always_comb begin
		distance_next = dist_q;
		if (ctrl.fail) begin
			distance_next = '0;
		end else if (ctrl.capture) begin
			distance_next = acc_val;
		end
	end

	// Hold the accumulator and the stored distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q_q   <= '0;
			acc_r_q   <= '0;
			acc_sat_q <= 1'b0;
			dist_q    <= '0;
		end else if (fire) begin
			dist_q <= distance_next;
			if (ctrl.start) begin
				acc_q_q   <= uer_pkg::DIST_STEP_Q;
				acc_r_q   <= uer_pkg::DIST_STEP_R;
				acc_sat_q <= 1'b0;
			end else if (ctrl.step) begin
				acc_q_q   <= q_sum[uer_pkg::DIST_W-1:0];
				acc_r_q   <= r_fix[uer_pkg::REM_W-1:0];
				acc_sat_q <= acc_sat_q | q_sum[uer_pkg::DIST_W];
			end
		end
	end

endmodule

// ===== rtl/uer_seq.sv =====
// Phase sequencer: trigger timing, echo wait, pulse timing and timeouts.
module uer_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 echo_level,
	input  uer_pkg::cfg_t        cfg,
	output logic                 trigger_level,
	output logic                 sample_done,
	output logic                 timed_out,
	output uer_pkg::dist_ctrl_t  ctrl
);

	uer_pkg::phase_t                phase_q;
	uer_pkg::phase_t                ph;
	logic [uer_pkg::COUNT_W-1:0]    count_q;
	logic [uer_pkg::COUNT_W-1:0]    cnt;
	logic                           settled;

	// Phase register and tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uer_pkg::PH_TRIG_LOW;
			count_q <= '0;
		end else if (fire) begin
			phase_q <= ph;
			count_q <= cnt;
		end
	end

	// Next phase and outputs; zero-length phases fall through in the same tick
	always_comb begin
		ph            = phase_q;
		cnt           = count_q;
		settled       = 1'b0;
		trigger_level = 1'b0;
		sample_done   = 1'b0;
		timed_out     = 1'b0;
		ctrl          = '0;

		unique case (phase_q)
			uer_pkg::PH_TRIG_LOW, uer_pkg::PH_TRIG_HIGH, uer_pkg::PH_WAIT_RISE,
			uer_pkg::PH_MEASURE, uer_pkg::PH_IDLE: begin
				ph = phase_q;
			end
			default: begin
				ph  = uer_pkg::PH_TRIG_LOW;
				cnt = '0;
			end
		endcase

		if (ph == uer_pkg::PH_IDLE) begin
			if (cnt >= cfg.idle_gap) begin
				ph  = uer_pkg::PH_TRIG_LOW;
				cnt = '0;
			end else begin
				cnt     = cnt + 1'b1;
				settled = 1'b1;
			end
		end

		if (!settled && ph == uer_pkg::PH_TRIG_LOW) begin
			if (cnt >= {{(uer_pkg::COUNT_W-uer_pkg::TRIG_LOW_W){1'b0}}, cfg.trig_low}) begin
				ph  = uer_pkg::PH_TRIG_HIGH;
				cnt = '0;
			end else begin
				cnt     = cnt + 1'b1;
				settled = 1'b1;
			end
		end

		if (!settled && ph == uer_pkg::PH_TRIG_HIGH) begin
			if (cnt >= {{(uer_pkg::COUNT_W-uer_pkg::TRIG_HIGH_W){1'b0}}, cfg.trig_high}) begin
				ph  = uer_pkg::PH_WAIT_RISE;
				cnt = '0;
			end else begin
				trigger_level = 1'b1;
				cnt           = cnt + 1'b1;
				settled       = 1'b1;
			end
		end

		// Wait for the echo rise
		if (!settled && ph == uer_pkg::PH_WAIT_RISE) begin
			if (echo_level) begin
				ph         = uer_pkg::PH_MEASURE;
				cnt        = uer_pkg::COUNT_W'(1);
				ctrl.start = 1'b1;
			end else begin
				cnt = cnt + 1'b1;
				if (cnt > {{(uer_pkg::COUNT_W-uer_pkg::TIMEOUT_W){1'b0}}, cfg.timeout}) begin
					ctrl.fail   = 1'b1;
					sample_done = 1'b1;
					timed_out   = 1'b1;
					ph          = uer_pkg::PH_IDLE;
					cnt         = '0;
				end
			end
		end else if (!settled && ph == uer_pkg::PH_MEASURE) begin
			// Time the echo pulse
			if (!echo_level) begin
				ctrl.capture = 1'b1;
				sample_done  = 1'b1;
				ph           = uer_pkg::PH_IDLE;
				cnt          = '0;
			end else begin
				cnt       = cnt + 1'b1;
				ctrl.step = 1'b1;
				if (cnt > {{(uer_pkg::COUNT_W-uer_pkg::TIMEOUT_W){1'b0}}, cfg.timeout}) begin
					ctrl.fail   = 1'b1;
					sample_done = 1'b1;
					timed_out   = 1'b1;
					ph          = uer_pkg::PH_IDLE;
					cnt         = '0;
				end
			end
		end
	end

endmodule
